// ===== hw/rtl/gbce_pkg.sv =====
// Shared types, constants and pixel packing helpers for the glyph bitmap
// color expander. No dependencies; every other file of the block imports it.
package gbce_pkg;

    // Default widths of the parameterized coordinate and offset fields.
    localparam int COORD_WIDTH_DEF  = 12;
    localparam int OFFSET_WIDTH_DEF = 26;

    // Fixed field widths.
    localparam int LB_W     = 14;
    localparam int FD_W     = 6;
    localparam int COLOR_W  = 32;
    localparam int PITCH_W  = 8;
    localparam int GD_W     = 8;
    localparam int DATA_W   = 8;
    localparam int CNT_W    = 3;
    localparam int STATUS_W = 2;
    localparam int CFG_IDX_W = 2;

    // One lane per bit of a 1 bpp bitmap byte.
    localparam int LANES   = 8;
    localparam int LCNT_W  = $clog2(LANES + 1);

    // Request types.
    localparam logic REQ_START = 1'b0;
    localparam logic REQ_DATA  = 1'b1;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_LINE_BYTES  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_DEPTH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FORE_COLOR  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BACK_COLOR  = 2'd3;

    // Supported depths.
    localparam logic [FD_W-1:0] FD_8BPP  = 6'd8;
    localparam logic [FD_W-1:0] FD_16BPP = 6'd16;
    localparam logic [FD_W-1:0] FD_32BPP = 6'd32;
    localparam logic [FD_W-1:0] FD_RESET = FD_16BPP;
    localparam logic [GD_W-1:0] GD_1BPP  = 8'd1;
    localparam logic [GD_W-1:0] GD_8BPP  = 8'd8;

    localparam logic [PITCH_W-1:0] BIR_MAX = 8'hFF;

    // Result status codes.
    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_BAD_FRAME = 2'd1,
        ST_BAD_GLYPH = 2'd2
    } t_status;

    // Everything of one result word except its byte offset.
    typedef struct packed {
        logic [COLOR_W-1:0] value;
        logic [CNT_W-1:0]   count;
        t_status            status;
        logic               done;
        logic               last;
    } t_word_info;

    // True for the frame depths the block can write.
    function automatic logic frame_depth_ok(input logic [FD_W-1:0] depth);
        return (depth == FD_8BPP) || (depth == FD_16BPP) || (depth == FD_32BPP);
    endfunction

    // Left shift that turns a pixel column into a byte column.
    function automatic logic [1:0] depth_shift(input logic [FD_W-1:0] depth);
        logic [1:0] sh;
        unique case (depth)
            FD_16BPP: sh = 2'd1;
            FD_32BPP: sh = 2'd2;
            default:  sh = 2'd0;
        endcase
        return sh;
    endfunction

    // Bytes written for one pixel.
    function automatic logic [CNT_W-1:0] pixel_bytes(input logic [FD_W-1:0] depth);
        logic [CNT_W-1:0] cnt;
        unique case (depth)
            FD_8BPP:  cnt = 3'd1;
            FD_16BPP: cnt = 3'd2;
            FD_32BPP: cnt = 3'd4;
            default:  cnt = 3'd0;
        endcase
        return cnt;
    endfunction

    // Converts a 0x00RRGGBB color into the frame buffer format.
    function automatic logic [COLOR_W-1:0] pack_pixel(input logic [COLOR_W-1:0] color,
                                                      input logic [FD_W-1:0]    depth);
        logic [COLOR_W-1:0] val;
        unique case (depth)
            FD_8BPP:  val = {24'd0, color[7:0]};
            FD_16BPP: val = {16'd0, color[23:19], color[15:10], color[7:3]};
            FD_32BPP: val = color;
            default:  val = '0;
        endcase
        return val;
    endfunction

endpackage

// ===== hw/rtl/gbce_req_if.sv =====
// Request channel of the glyph expander: start words and bitmap byte words.
// Depends on gbce_pkg for the fixed field widths.
interface gbce_req_if #(
    parameter int COORD_WIDTH = gbce_pkg::COORD_WIDTH_DEF
);
    import gbce_pkg::*;

    logic                   valid;
    logic                   ready;
    logic                   req_type;
    logic [COORD_WIDTH-1:0] box_left;
    logic [COORD_WIDTH-1:0] box_top;
    logic [COORD_WIDTH:0]   box_right_end;
    logic [COORD_WIDTH:0]   box_bottom_end;
    logic [PITCH_W-1:0]     row_pitch;
    logic [GD_W-1:0]        glyph_depth;
    logic [DATA_W-1:0]      data_byte;

    modport source (
        output valid, req_type, box_left, box_top, box_right_end, box_bottom_end,
               row_pitch, glyph_depth, data_byte,
        input  ready
    );

    modport sink (
        input  valid, req_type, box_left, box_top, box_right_end, box_bottom_end,
               row_pitch, glyph_depth, data_byte,
        output ready
    );
endinterface

// ===== hw/rtl/gbce_res_if.sv =====
// Result channel of the glyph expander: one frame buffer write per word.
// Depends on gbce_pkg for the fixed field widths.
interface gbce_res_if #(
    parameter int OFFSET_WIDTH = gbce_pkg::OFFSET_WIDTH_DEF
);
    import gbce_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [OFFSET_WIDTH-1:0] byte_offset;
    logic [COLOR_W-1:0]      pixel_value;
    logic [CNT_W-1:0]        byte_count;
    logic [STATUS_W-1:0]     status;
    logic                    glyph_done;
    logic                    last_of_run;

    modport source (
        output valid, byte_offset, pixel_value, byte_count, status, glyph_done,
               last_of_run,
        input  ready
    );

    modport sink (
        input  valid, byte_offset, pixel_value, byte_count, status, glyph_done,
               last_of_run,
        output ready
    );
endinterface

// ===== hw/rtl/gbce_lane.sv =====
// One pixel lane: column, in-box test, byte offset and packed color of one pixel.
// Depends on gbce_pkg for widths and the pixel packing functions.
module gbce_lane #(
    parameter int COORD_WIDTH  = gbce_pkg::COORD_WIDTH_DEF,
    parameter int OFFSET_WIDTH = gbce_pkg::OFFSET_WIDTH_DEF,
    parameter int LANE_IDX     = 0
) (
    input  logic [COORD_WIDTH:0]           i_x,
    input  logic [COORD_WIDTH:0]           i_right_end,
    input  logic [OFFSET_WIDTH-1:0]        i_row_base,
    input  logic [gbce_pkg::FD_W-1:0]      i_frame_depth,
    input  logic                           i_set,
    input  logic [gbce_pkg::COLOR_W-1:0]   i_fore,
    input  logic [gbce_pkg::COLOR_W-1:0]   i_back,
    output logic                           o_live,
    output logic [OFFSET_WIDTH-1:0]        o_offset,
    output logic [gbce_pkg::COLOR_W-1:0]   o_value,
    output logic [gbce_pkg::CNT_W-1:0]     o_count
);
    import gbce_pkg::*;

    logic [COORD_WIDTH+1:0] w_xk;
    logic [COORD_WIDTH+3:0] w_xbytes;

    // Column of this lane's pixel and whether it still lies inside the box.
    assign w_xk   = {1'b0, i_x} + (COORD_WIDTH+2)'(LANE_IDX);
    assign o_live = w_xk < {1'b0, i_right_end};

    // Byte column is the pixel column times the bytes per pixel.
    assign w_xbytes = {2'b00, w_xk} << depth_shift(i_frame_depth);
    assign o_offset = i_row_base + OFFSET_WIDTH'(w_xbytes);

    // Pixel color in frame format.
    assign o_value = pack_pixel(i_set ? i_fore : i_back, i_frame_depth);
    assign o_count = pixel_bytes(i_frame_depth);
endmodule

// ===== hw/rtl/gbce_batch.sv =====
// Result merge and drain stage: takes the words of all lanes for one request
// and hands them out one per ready cycle. Depends on gbce_pkg and gbce_res_if.
module gbce_batch #(
    parameter int OFFSET_WIDTH = gbce_pkg::OFFSET_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_load,
    input  logic [gbce_pkg::LCNT_W-1:0]   i_load_cnt,
    input  logic [OFFSET_WIDTH-1:0]       i_off  [gbce_pkg::LANES],
    input  gbce_pkg::t_word_info          i_info [gbce_pkg::LANES],
    output logic                          o_can_take,
    output logic [gbce_pkg::LCNT_W-1:0]   o_cnt,
    gbce_res_if.source                    o_res
);
    import gbce_pkg::*;

    logic [OFFSET_WIDTH-1:0] r_off  [LANES];
    t_word_info              r_info [LANES];
    logic [LCNT_W-1:0]       r_cnt;
    logic [LCNT_W-1:0]       n_cnt;
    logic                    w_pop;

    assign w_pop      = o_res.valid && o_res.ready;
    // A new batch may enter once the stage is empty or its last word leaves now.
    assign o_can_take = (r_cnt == '0) || ((r_cnt == LCNT_W'(1)) && o_res.ready);
    assign o_cnt      = r_cnt;

    always_comb begin
        if (i_load) begin
            n_cnt = i_load_cnt;
        end else if (w_pop) begin
            n_cnt = r_cnt - LCNT_W'(1);
        end else begin
            n_cnt = r_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    // Word storage: loaded in parallel, shifted toward the head on each pop.
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_off  <= i_off;
            r_info <= i_info;
        end else if (w_pop) begin
            for (int i = 0; i < LANES - 1; i++) begin
                r_off[i]  <= r_off[i+1];
                r_info[i] <= r_info[i+1];
            end
        end
    end

    // The head of the storage drives the result channel.
    assign o_res.valid       = r_cnt != '0;
    assign o_res.byte_offset = r_off[0];
    assign o_res.pixel_value = r_info[0].value;
    assign o_res.byte_count  = r_info[0].count;
    assign o_res.status      = r_info[0].status;
    assign o_res.glyph_done  = r_info[0].done;
    assign o_res.last_of_run = r_info[0].last;
endmodule

// ===== hw/rtl/glyph_bitmap_color_expander_unit.sv =====
// Glyph bitmap color expander: monochrome or 8 bpp glyph bytes to frame writes.
// The first write of a request word appears in the cycle after acceptance.
// Throughput: a 1 bpp byte gives up to 8 writes, an 8 bpp byte one; the result
// port moves one word per cycle while its ready is high, and the next request
// is taken in the cycle its predecessor's last write leaves.
// Reset (synchronous, active low): registers to reset values, no glyph open.
module glyph_bitmap_color_expander_unit #(
    parameter int COORD_WIDTH  = gbce_pkg::COORD_WIDTH_DEF,
    parameter int OFFSET_WIDTH = gbce_pkg::OFFSET_WIDTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [gbce_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [gbce_pkg::COLOR_W-1:0]     i_cfg_data,
    gbce_req_if.sink                         i_req,
    gbce_res_if.source                       o_res
);
    import gbce_pkg::*;

    localparam int XW = COORD_WIDTH + 1;
    localparam int PW = XW + LB_W;

    // Configuration registers.
    logic [LB_W-1:0]    r_line_bytes;
    logic [FD_W-1:0]    r_frame_depth;
    logic [COLOR_W-1:0] r_fore;
    logic [COLOR_W-1:0] r_back;

    // Glyph walk state.
    logic [XW-1:0]           r_x;
    logic [XW-1:0]           r_y;
    logic [PITCH_W-1:0]      r_bir;
    logic [COORD_WIDTH-1:0]  r_left;
    logic [XW-1:0]           r_re;
    logic [XW-1:0]           r_be;
    logic [PITCH_W-1:0]      r_pitch;
    logic                    r_active;
    logic                    r_mode8;
    logic [OFFSET_WIDTH-1:0] r_row_base;

    logic [LANES-1:0]        w_live;
    logic [OFFSET_WIDTH-1:0] w_lane_off  [LANES];
    logic [COLOR_W-1:0]      w_lane_val  [LANES];
    logic [CNT_W-1:0]        w_lane_cnt  [LANES];
    logic [OFFSET_WIDTH-1:0] w_load_off  [LANES];
    t_word_info              w_load_info [LANES];
    logic [LCNT_W-1:0]       w_nlive;
    logic [LCNT_W-1:0]       w_npix;
    logic [LCNT_W-1:0]       w_nload;
    logic [LCNT_W-1:0]       w_bcnt;

    logic           w_acc, w_start, w_data, w_can_take;
    logic           w_gd_ok, w_gd8, w_box_ok;
    logic           w_err_frame, w_err_glyph, w_gend, w_adv, w_row_full, w_last_row;
    logic [XW:0]    w_x_new;
    logic [PITCH_W-1:0] w_bir_inc;
    logic           w_lb_wr;
    logic [XW-1:0]  w_mul_a;
    logic [LB_W-1:0] w_mul_b;
    logic [PW-1:0]  w_prod;

    // Request handshake.
    assign i_req.ready = w_can_take;
    assign w_acc       = i_req.valid && w_can_take;
    assign w_start     = w_acc && (i_req.req_type == REQ_START);
    assign w_data      = w_acc && (i_req.req_type == REQ_DATA) && r_active;

    // Configuration writes.
    assign w_lb_wr = i_cfg_we && (i_cfg_idx == REG_LINE_BYTES);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_bytes  <= '0;
            r_frame_depth <= FD_RESET;
            r_fore        <= '0;
            r_back        <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_LINE_BYTES:  r_line_bytes  <= i_cfg_data[LB_W-1:0];
                REG_FRAME_DEPTH: r_frame_depth <= i_cfg_data[FD_W-1:0];
                REG_FORE_COLOR:  r_fore        <= i_cfg_data;
                REG_BACK_COLOR:  r_back        <= i_cfg_data;
                default:         r_line_bytes  <= r_line_bytes;
            endcase
        end
    end

    // Pixel lanes, one per bit of a 1 bpp byte; lane 0 serves 8 bpp mode.
    for (genvar k = 0; k < LANES; k++) begin : g_lane
        logic w_set;
        assign w_set = r_mode8 ? (i_req.data_byte != '0) : i_req.data_byte[LANES-1-k];

        gbce_lane #(
            .COORD_WIDTH  (COORD_WIDTH),
            .OFFSET_WIDTH (OFFSET_WIDTH),
            .LANE_IDX     (k)
        ) u_lane (
            .i_x           (r_x),
            .i_right_end   (r_re),
            .i_row_base    (r_row_base),
            .i_frame_depth (r_frame_depth),
            .i_set         (w_set),
            .i_fore        (r_fore),
            .i_back        (r_back),
            .o_live        (w_live[k]),
            .o_offset      (w_lane_off[k]),
            .o_value       (w_lane_val[k]),
            .o_count       (w_lane_cnt[k])
        );
    end

    // Number of lanes whose pixel is still inside the current row.
    always_comb begin
        logic [LCNT_W-1:0] sum;
        sum = '0;
        for (int k = 0; k < LANES; k++) begin
            sum = sum + LCNT_W'(w_live[k]);
        end
        w_nlive = sum;
    end

    // Row and glyph end decisions for a bitmap byte.
    assign w_npix      = r_mode8 ? LCNT_W'(1) : w_nlive;
    assign w_x_new     = {1'b0, r_x} + (XW+1)'(w_npix);
    assign w_row_full  = w_x_new >= {1'b0, r_re};
    assign w_last_row  = ({1'b0, r_y} + (XW+1)'(1)) >= {1'b0, r_be};
    assign w_err_frame = w_data && (w_npix != '0) && !frame_depth_ok(r_frame_depth);
    assign w_gend      = w_data && !w_err_frame && (w_npix != '0) && w_row_full && w_last_row;
    assign w_bir_inc   = (r_bir == BIR_MAX) ? r_bir : r_bir + PITCH_W'(1);
    assign w_adv       = w_data && !w_err_frame && !w_gend && w_row_full &&
                         (r_mode8 || (w_bir_inc >= r_pitch));

    // Start word checks.
    assign w_gd_ok     = (i_req.glyph_depth == GD_1BPP) || (i_req.glyph_depth == GD_8BPP);
    assign w_gd8       = i_req.glyph_depth == GD_8BPP;
    assign w_box_ok    = (i_req.box_right_end > {1'b0, i_req.box_left}) &&
                         (i_req.box_bottom_end > {1'b0, i_req.box_top});
    assign w_err_glyph = w_start && !w_gd_ok;

    // Merge lane words into one batch, or a single error word.
    always_comb begin
        for (int k = 0; k < LANES; k++) begin
            w_load_off[k]        = w_lane_off[k];
            w_load_info[k].value  = w_lane_val[k];
            w_load_info[k].count  = w_lane_cnt[k];
            w_load_info[k].status = ST_OK;
            w_load_info[k].last   = LCNT_W'(k + 1) == w_nload;
            w_load_info[k].done   = (LCNT_W'(k + 1) == w_nload) && w_gend;
        end
        if (w_err_glyph || w_err_frame) begin
            w_load_off[0]        = '0;
            w_load_info[0].value  = '0;
            w_load_info[0].count  = '0;
            w_load_info[0].status = w_err_glyph ? ST_BAD_GLYPH : ST_BAD_FRAME;
            w_load_info[0].done   = 1'b1;
            w_load_info[0].last   = 1'b1;
        end
    end

    always_comb begin
        priority if (w_err_glyph || w_err_frame) begin
            w_nload = LCNT_W'(1);
        end else if (w_data) begin
            w_nload = w_npix;
        end else begin
            w_nload = '0;
        end
    end

    // Row base y * line_bytes: multiplied on a start or a stride change,
    // stepped by the stride on each row advance.
    assign w_mul_a = w_start ? XW'(i_req.box_top) : r_y;
    assign w_mul_b = w_lb_wr ? i_cfg_data[LB_W-1:0] : r_line_bytes;
    assign w_prod  = PW'(w_mul_a) * PW'(w_mul_b);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_base <= '0;
        end else if (w_start || w_lb_wr) begin
            r_row_base <= OFFSET_WIDTH'(w_prod);
        end else if (w_adv) begin
            r_row_base <= r_row_base + OFFSET_WIDTH'(r_line_bytes);
        end
    end

    // Glyph walk state update.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x      <= '0;
            r_y      <= '0;
            r_bir    <= '0;
            r_left   <= '0;
            r_re     <= '0;
            r_be     <= '0;
            r_pitch  <= '0;
            r_active <= 1'b0;
            r_mode8  <= 1'b0;
        end else if (w_start) begin
            r_left   <= i_req.box_left;
            r_re     <= i_req.box_right_end;
            r_be     <= i_req.box_bottom_end;
            r_pitch  <= i_req.row_pitch;
            r_x      <= XW'(i_req.box_left);
            r_y      <= XW'(i_req.box_top);
            r_bir    <= '0;
            r_active <= w_gd_ok && w_box_ok;
            r_mode8  <= w_gd_ok && w_box_ok && w_gd8;
        end else if (w_err_frame) begin
            r_active <= 1'b0;
            r_mode8  <= 1'b0;
        end else if (w_data) begin
            if (w_gend) begin
                r_active <= 1'b0;
            end
            if (w_adv) begin
                r_x <= XW'(r_left);
                r_y <= r_y + XW'(1);
            end else begin
                r_x <= w_x_new[XW-1:0];
            end
            if (!r_mode8) begin
                r_bir <= w_adv ? '0 : w_bir_inc;
            end
        end
    end

    // Result merge and drain stage.
    gbce_batch #(
        .OFFSET_WIDTH (OFFSET_WIDTH)
    ) u_batch (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (w_acc),
        .i_load_cnt (w_nload),
        .i_off      (w_load_off),
        .i_info     (w_load_info),
        .o_can_take (w_can_take),
        .o_cnt      (w_bcnt),
        .o_res      (o_res)
    );

`ifndef NO_ASSERTIONS
    // The drain stage never holds more words than there are lanes.
    a_batch_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_bcnt <= LCNT_W'(LANES))
        else $error("result batch overfilled");

    // An 8 bpp byte produces at most one write.
    a_mode8_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && r_mode8 && r_active) |=> (w_bcnt <= LCNT_W'(1)))
        else $error("8 bpp byte produced more than one write");

    // Error words carry no write and close both the glyph and the run.
    a_error_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> ((o_res.status == ST_OK) ||
                         ((o_res.byte_count == '0) && o_res.glyph_done && o_res.last_of_run)))
        else $error("error word malformed");

    // An open glyph's row is in the box; its column is at most the right end.
    a_walk_in_box: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active |-> ((r_y < r_be) && (r_x <= r_re)))
        else $error("glyph walk left its box");
`endif
endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for glyph_bitmap_color_expander_unit.
// Depends on gbce_pkg and the gbce_req_if / gbce_res_if channel interfaces; a
// built-in model of the expander predicts every frame buffer write word.
module tb;
    import gbce_pkg::*;

    localparam int CW = COORD_WIDTH_DEF;
    localparam int OW = OFFSET_WIDTH_DEF;

    // One request word as the sender drives it.
    typedef struct packed {
        logic                req_type;
        logic [CW-1:0]       box_left;
        logic [CW-1:0]       box_top;
        logic [CW:0]         box_right_end;
        logic [CW:0]         box_bottom_end;
        logic [PITCH_W-1:0]  row_pitch;
        logic [GD_W-1:0]     glyph_depth;
        logic [DATA_W-1:0]   data_byte;
    } t_glyph_req;

    // One frame buffer write word as the block reports it.
    typedef struct packed {
        logic [OW-1:0]      off;
        logic [COLOR_W-1:0] value;
        logic [CNT_W-1:0]   count;
        t_status            status;
        logic               done;
        logic               last;
    } t_fb_write;

    // One row of the directed plan: a register write or a request word.
    typedef struct {
        bit                    is_reg;
        logic [CFG_IDX_W-1:0]  reg_idx;
        logic [COLOR_W-1:0]    reg_val;
        t_glyph_req            req;
        bit                    typed;
        t_fb_write             word;
    } t_plan_step;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   cfg_we;
    logic [CFG_IDX_W-1:0]   cfg_idx;
    logic [COLOR_W-1:0]     cfg_data;

    gbce_req_if req_if ();
    gbce_res_if res_if ();

    glyph_bitmap_color_expander_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_req      (req_if),
        .o_res      (res_if)
    );

    // Model copy of the registers.
    logic [LB_W-1:0]    cfg_line;
    logic [FD_W-1:0]    cfg_depth;
    logic [COLOR_W-1:0] cfg_fore;
    logic [COLOR_W-1:0] cfg_back;

    // Model copy of the glyph walk.
    logic [CW:0]        gx;
    logic [CW:0]        gy;
    logic [PITCH_W-1:0] row_bytes;
    logic [CW-1:0]      g_left;
    logic [CW:0]        g_right;
    logic [CW:0]        g_bottom;
    logic [PITCH_W-1:0] g_pitch;
    bit                 g_active;
    bit                 g_mode8;

    t_fb_write fb_writes_due[$];
    int        mismatch_count;
    bit        quiet;
    int        next_gap;
    bit        valid_held;
    int        res_hold;

    always #5 i_clk = ~i_clk;

    // Hard limit on the run time.
    initial begin
        #5_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    task automatic report_mismatch(input string what);
        mismatch_count++;
        $display("%0t: mismatch: %s", $time, what);
    endtask

    function automatic int draw_gap();
        return quiet ? 0 : int'($urandom_range(0, 18));
    endfunction

    // One pixel of the glyph: a write word, or the frame depth error word.
    task automatic emit_pixel_write(input logic lit, inout bit stop);
        logic [COLOR_W-1:0] color;
        logic [63:0]        addr;
        t_fb_write          w;
        color = lit ? cfg_fore : cfg_back;
        w = '0;
        w.status = ST_OK;
        case (cfg_depth)
            FD_8BPP: begin
                w.value = color & 32'hFF;
                w.count = 3'd1;
            end
            FD_16BPP: begin
                w.value = (((color >> 19) & 32'h1F) << 11) |
                          (((color >> 10) & 32'h3F) << 5) |
                          ((color >> 3) & 32'h1F);
                w.count = 3'd2;
            end
            FD_32BPP: begin
                w.value = color;
                w.count = 3'd4;
            end
            default: begin
                w.status = ST_BAD_FRAME;
                w.done   = 1'b1;
            end
        endcase
        if (w.status == ST_BAD_FRAME) begin
            g_active = 1'b0;
            g_mode8  = 1'b0;
            stop     = 1'b1;
        end else begin
            addr  = 64'(gy) * 64'(cfg_line) + ((64'(gx) * 64'(cfg_depth)) >> 3);
            w.off = addr[OW-1:0];
            gx    = gx + 1'b1;
            if (gx >= g_right) begin
                if (gy + 1'b1 >= g_bottom) begin
                    w.done   = 1'b1;
                    g_active = 1'b0;
                    stop     = 1'b1;
                end else if (g_mode8) begin
                    gx = {1'b0, g_left};
                    gy = gy + 1'b1;
                end
            end
        end
        fb_writes_due.push_back(w);
    endtask

    // Expands one accepted request word into the writes it must cause.
    task automatic expand_request(input t_glyph_req r);
        int        first;
        int        k;
        bit        stop;
        t_fb_write w;
        first = fb_writes_due.size();
        stop  = 1'b0;
        if (r.req_type == REQ_START) begin
            g_active  = 1'b0;
            g_mode8   = 1'b0;
            g_left    = r.box_left;
            g_right   = r.box_right_end;
            g_bottom  = r.box_bottom_end;
            g_pitch   = r.row_pitch;
            gx        = {1'b0, r.box_left};
            gy        = {1'b0, r.box_top};
            row_bytes = '0;
            if (r.glyph_depth != GD_1BPP && r.glyph_depth != GD_8BPP) begin
                w = '0;
                w.status = ST_BAD_GLYPH;
                w.done   = 1'b1;
                w.last   = 1'b1;
                fb_writes_due.push_back(w);
            end else if (r.box_right_end > r.box_left && r.box_bottom_end > r.box_top) begin
                g_active = 1'b1;
                g_mode8  = (r.glyph_depth == GD_8BPP);
            end
        end else if (g_active) begin
            if (g_mode8) begin
                emit_pixel_write(r.data_byte != 0, stop);
            end else begin
                for (k = 7; k >= 0 && !stop && gx < g_right; k--) begin
                    emit_pixel_write(r.data_byte[k], stop);
                end
                // Row bookkeeping: padding bytes up to the pitch close the row.
                if (g_active) begin
                    if (row_bytes != BIR_MAX) begin
                        row_bytes = row_bytes + 1'b1;
                    end
                    if (gx >= g_right && row_bytes >= g_pitch) begin
                        gx        = {1'b0, g_left};
                        gy        = gy + 1'b1;
                        row_bytes = '0;
                    end
                end
            end
            if (fb_writes_due.size() > first) begin
                fb_writes_due[fb_writes_due.size() - 1].last = 1'b1;
            end
        end
    endtask

    // Drives one request word, waits for the handshake and predicts its writes.
    task automatic send_word(input t_glyph_req r, input bit typed, input t_fb_write want,
                             output bit used);
        int first;
        repeat (next_gap) @(posedge i_clk);
        req_if.valid          <= 1'b1;
        req_if.req_type       <= r.req_type;
        req_if.box_left       <= r.box_left;
        req_if.box_top        <= r.box_top;
        req_if.box_right_end  <= r.box_right_end;
        req_if.box_bottom_end <= r.box_bottom_end;
        req_if.row_pitch      <= r.row_pitch;
        req_if.glyph_depth    <= r.glyph_depth;
        req_if.data_byte      <= r.data_byte;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
        first = fb_writes_due.size();
        used  = (r.req_type == REQ_START) || g_active;
        expand_request(r);
        // A typed row replaces the predicted word with the one written down.
        if (typed) begin
            while (fb_writes_due.size() > first) void'(fb_writes_due.pop_back());
            fb_writes_due.push_back(want);
        end
        next_gap   = draw_gap();
        valid_held = (next_gap == 0);
        if (!valid_held) begin
            req_if.valid <= 1'b0;
        end
    endtask

    // Holds the sender until every expected write has arrived.
    task automatic settle();
        if (valid_held) begin
            req_if.valid <= 1'b0;
            valid_held = 1'b0;
        end
        next_gap = 0;
        while (fb_writes_due.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COLOR_W-1:0] val);
        @(posedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_LINE_BYTES:  cfg_line  = val[LB_W-1:0];
            REG_FRAME_DEPTH: cfg_depth = val[FD_W-1:0];
            REG_FORE_COLOR:  cfg_fore  = val;
            REG_BACK_COLOR:  cfg_back  = val;
            default: ;
        endcase
    endtask

    // Request word with every field random.
    function automatic t_glyph_req junk_req();
        t_glyph_req r;
        r.req_type       = 1'($urandom_range(0, 1));
        r.box_left       = CW'($urandom_range(0, 4095));
        r.box_top        = CW'($urandom_range(0, 4095));
        r.box_right_end  = (CW + 1)'($urandom_range(0, 4096));
        r.box_bottom_end = (CW + 1)'($urandom_range(0, 4096));
        r.row_pitch      = PITCH_W'($urandom_range(0, 255));
        r.glyph_depth    = GD_W'($urandom_range(0, 255));
        r.data_byte      = DATA_W'($urandom_range(0, 255));
        return r;
    endfunction

    function automatic t_plan_step reg_step(input logic [CFG_IDX_W-1:0] idx,
                                            input logic [COLOR_W-1:0] val);
        t_plan_step s;
        s.is_reg  = 1'b1;
        s.reg_idx = idx;
        s.reg_val = val;
        s.req     = '0;
        s.typed   = 1'b0;
        s.word    = '0;
        return s;
    endfunction

    function automatic t_plan_step start_step(input int left, input int top, input int right_end,
                                              input int bottom_end, input int pitch,
                                              input int depth);
        t_plan_step s;
        s = reg_step(REG_LINE_BYTES, '0);
        s.is_reg             = 1'b0;
        s.req.req_type       = REQ_START;
        s.req.box_left       = CW'(left);
        s.req.box_top        = CW'(top);
        s.req.box_right_end  = (CW + 1)'(right_end);
        s.req.box_bottom_end = (CW + 1)'(bottom_end);
        s.req.row_pitch      = PITCH_W'(pitch);
        s.req.glyph_depth    = GD_W'(depth);
        return s;
    endfunction

    function automatic t_plan_step data_step(input int b);
        t_plan_step s;
        s = reg_step(REG_LINE_BYTES, '0);
        s.is_reg        = 1'b0;
        s.req.req_type  = REQ_DATA;
        s.req.data_byte = DATA_W'(b);
        return s;
    endfunction

    function automatic t_plan_step with_word(input t_plan_step s, input t_fb_write w);
        t_plan_step t;
        t       = s;
        t.typed = 1'b1;
        t.word  = w;
        return t;
    endfunction

    // Result side: random stalls and the word-by-word comparison.
    always @(posedge i_clk) begin : res_side
        t_fb_write got;
        t_fb_write want;
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
            res_hold = 0;
        end else if (res_if.valid && res_if.ready) begin
            got.off   = res_if.byte_offset;
            got.value = res_if.pixel_value;
            got.count = res_if.byte_count;
            got.status = t_status'(res_if.status);
            got.done  = res_if.glyph_done;
            got.last  = res_if.last_of_run;
            if (fb_writes_due.size() == 0) begin
                report_mismatch($sformatf("write word %h with nothing expected", got));
            end else begin
                want = fb_writes_due.pop_front();
                if (got.off !== want.off)
                    report_mismatch($sformatf("byte_offset %h, expected %h", got.off, want.off));
                if (got.value !== want.value)
                    report_mismatch($sformatf("pixel_value %h, expected %h",
                                              got.value, want.value));
                if (got.count !== want.count)
                    report_mismatch($sformatf("byte_count %0d, expected %0d",
                                              got.count, want.count));
                if (got.status !== want.status)
                    report_mismatch($sformatf("status %0d, expected %0d",
                                              got.status, want.status));
                if (got.done !== want.done)
                    report_mismatch($sformatf("glyph_done %b, expected %b", got.done, want.done));
                if (got.last !== want.last)
                    report_mismatch($sformatf("last_of_run %b, expected %b",
                                              got.last, want.last));
            end
            res_hold = draw_gap();
            if (res_hold != 0) begin
                res_if.ready <= 1'b0;
            end
        end else if (!res_if.ready) begin
            if (res_hold > 0) begin
                res_hold--;
            end
            if (res_hold == 0) begin
                res_if.ready <= 1'b1;
            end
        end
    end

    // Stimulus: directed plan, then phases of random glyphs.
    initial begin
        t_plan_step plan[$];
        t_glyph_req r;
        bit         used;
        int         fed;
        int         w;
        int         h;
        int         need;
        int         gd;
        int         row_len;
        int         nbytes;
        int         j;

        i_clk          = 1'b0;
        i_rst_n        = 1'b0;
        cfg_we         = 1'b0;
        cfg_idx        = '0;
        cfg_data       = '0;
        req_if.valid   = 1'b0;
        req_if.req_type = REQ_START;
        req_if.box_left = '0;
        req_if.box_top  = '0;
        req_if.box_right_end  = '0;
        req_if.box_bottom_end = '0;
        req_if.row_pitch   = '0;
        req_if.glyph_depth = '0;
        req_if.data_byte   = '0;
        res_if.ready   = 1'b0;
        mismatch_count = 0;
        quiet      = 1'b0;
        next_gap   = 0;
        valid_held = 1'b0;
        fed        = 0;

        // Register and glyph state after reset.
        cfg_line  = '0;
        cfg_depth = FD_RESET;
        cfg_fore  = '0;
        cfg_back  = '0;
        gx = '0; gy = '0; row_bytes = '0;
        g_left = '0; g_right = '0; g_bottom = '0; g_pitch = '0;
        g_active = 1'b0; g_mode8 = 1'b0;

        // Directed plan. Data before any glyph is ignored; then a one pixel
        // glyph with the reset registers.
        plan.push_back(data_step(8'hFF));
        plan.push_back(start_step(0, 0, 1, 1, 0, GD_8BPP));
        plan.push_back(with_word(data_step(8'hFF), t_fb_write'{off: '0, value: '0, count: 3'd2,
                                 status: ST_OK, done: 1'b1, last: 1'b1}));
        // Unsupported glyph depths, then data that must be dropped.
        plan.push_back(with_word(start_step(7, 9, 20, 20, 1, 0), t_fb_write'{off: '0,
                                 value: '0, count: '0, status: ST_BAD_GLYPH, done: 1'b1,
                                 last: 1'b1}));
        plan.push_back(with_word(start_step(0, 0, 8, 8, 1, 255), t_fb_write'{off: '0,
                                 value: '0, count: '0, status: ST_BAD_GLYPH, done: 1'b1,
                                 last: 1'b1}));
        plan.push_back(data_step(8'hAA));
        // Extreme corner of the screen with the widest stride and 32 bpp.
        plan.push_back(reg_step(REG_LINE_BYTES, 32'd16383));
        plan.push_back(reg_step(REG_FRAME_DEPTH, 32'd32));
        plan.push_back(reg_step(REG_FORE_COLOR, 32'hFFFF_FFFF));
        plan.push_back(reg_step(REG_BACK_COLOR, 32'h0000_0000));
        plan.push_back(start_step(4095, 4095, 4096, 4096, 255, GD_1BPP));
        plan.push_back(with_word(data_step(8'h80), t_fb_write'{off: 26'h3FF_EFFD,
                                 value: 32'hFFFF_FFFF, count: 3'd4, status: ST_OK,
                                 done: 1'b1, last: 1'b1}));
        plan.push_back(data_step(8'h00));
        // Two rows of ten 1 bpp pixels with one padding byte per row; the
        // padding after the last row arrives with no glyph open.
        plan.push_back(reg_step(REG_LINE_BYTES, 32'd100));
        plan.push_back(reg_step(REG_FRAME_DEPTH, 32'd16));
        plan.push_back(reg_step(REG_FORE_COLOR, 32'h1234_5678));
        plan.push_back(reg_step(REG_BACK_COLOR, 32'h00AB_CDEF));
        plan.push_back(start_step(2, 3, 12, 5, 3, GD_1BPP));
        plan.push_back(data_step(8'hA5));
        plan.push_back(data_step(8'h3C));
        plan.push_back(data_step(8'hFF));
        plan.push_back(data_step(8'h0F));
        plan.push_back(data_step(8'hC0));
        plan.push_back(data_step(8'hFF));
        // Pitch of zero, then a new start abandons the open glyph.
        plan.push_back(start_step(0, 0, 20, 2, 0, GD_1BPP));
        plan.push_back(data_step(8'h81));
        plan.push_back(start_step(5, 5, 8, 6, 0, GD_8BPP));
        plan.push_back(data_step(8'h00));
        plan.push_back(data_step(8'h7F));
        // Frame depth becomes unsupported in the middle of a glyph.
        plan.push_back(reg_step(REG_FRAME_DEPTH, 32'd0));
        plan.push_back(with_word(data_step(8'h01), t_fb_write'{off: '0, value: '0,
                                 count: '0, status: ST_BAD_FRAME, done: 1'b1, last: 1'b1}));
        // Empty boxes leave the block closed.
        plan.push_back(reg_step(REG_FRAME_DEPTH, 32'd8));
        plan.push_back(start_step(10, 0, 10, 4, 1, GD_1BPP));
        plan.push_back(data_step(8'h55));
        plan.push_back(start_step(0, 100, 4, 50, 0, GD_8BPP));
        plan.push_back(data_step(8'h3C));

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        foreach (plan[i]) begin
            if (plan[i].is_reg) begin
                settle();
                write_reg(plan[i].reg_idx, plan[i].reg_val);
            end else begin
                send_word(plan[i].req, plan[i].typed, plan[i].word, used);
            end
        end

        // Random phases: new register settings, then a few glyphs.
        while (fed < 320) begin
            settle();
            quiet = ($urandom_range(0, 4) == 0);
            if ($urandom_range(0, 1)) begin
                case ($urandom_range(0, 3))
                    0:       write_reg(REG_LINE_BYTES, 32'd0);
                    1:       write_reg(REG_LINE_BYTES, 32'd16383);
                    default: write_reg(REG_LINE_BYTES, 32'($urandom_range(0, 16383)));
                endcase
            end
            if ($urandom_range(0, 1)) begin
                case ($urandom_range(0, 9))
                    0, 1, 2: write_reg(REG_FRAME_DEPTH, 32'(FD_8BPP));
                    3, 4, 5: write_reg(REG_FRAME_DEPTH, 32'(FD_16BPP));
                    6, 7:    write_reg(REG_FRAME_DEPTH, 32'(FD_32BPP));
                    default: write_reg(REG_FRAME_DEPTH, 32'($urandom_range(0, 32)));
                endcase
            end
            if ($urandom_range(0, 1)) begin
                case ($urandom_range(0, 3))
                    0:       write_reg(REG_FORE_COLOR, 32'h0);
                    1:       write_reg(REG_FORE_COLOR, 32'hFFFF_FFFF);
                    default: write_reg(REG_FORE_COLOR, $urandom);
                endcase
            end
            if ($urandom_range(0, 1)) begin
                case ($urandom_range(0, 3))
                    0:       write_reg(REG_BACK_COLOR, 32'h0);
                    1:       write_reg(REG_BACK_COLOR, 32'hFFFF_FFFF);
                    default: write_reg(REG_BACK_COLOR, $urandom);
                endcase
            end

            repeat ($urandom_range(2, 5)) begin
                if ($urandom_range(0, 9) == 0) begin
                    // Noise: random words, some starting huge or odd glyphs.
                    repeat ($urandom_range(1, 6)) begin
                        r = junk_req();
                        if (r.req_type == REQ_START && $urandom_range(0, 1)) begin
                            r.glyph_depth = $urandom_range(0, 1) ? GD_1BPP : GD_8BPP;
                        end
                        send_word(r, 1'b0, '0, used);
                        fed += used;
                    end
                end else begin
                    // Random glyph, well-formed box, at times a bad depth.
                    case ($urandom_range(0, 9))
                        0, 1, 2, 3, 4, 5: gd = GD_1BPP;
                        6, 7, 8:          gd = GD_8BPP;
                        default: begin
                            gd = $urandom_range(0, 255);
                            if (gd == GD_1BPP || gd == GD_8BPP) begin
                                gd = 0;
                            end
                        end
                    endcase
                    if (gd == GD_8BPP) begin
                        w = $urandom_range(1, 8);
                    end else begin
                        w = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 40)
                                                        : $urandom_range(1, 16);
                    end
                    h    = $urandom_range(1, 4);
                    need = (w + 7) / 8;
                    r = junk_req();
                    r.req_type       = REQ_START;
                    r.box_left       = CW'(($urandom_range(0, 5) == 0)
                                           ? 4096 - w : $urandom_range(0, 4096 - w));
                    r.box_top        = CW'(($urandom_range(0, 5) == 0)
                                           ? 4096 - h : $urandom_range(0, 4096 - h));
                    r.box_right_end  = (CW + 1)'(r.box_left + w);
                    r.box_bottom_end = (CW + 1)'(r.box_top + h);
                    r.glyph_depth    = GD_W'(gd);
                    if (gd == GD_1BPP) begin
                        case ($urandom_range(0, 5))
                            0:       r.row_pitch = '0;
                            1, 5:    r.row_pitch = PITCH_W'(need);
                            2:       r.row_pitch = PITCH_W'(need + $urandom_range(1, 2));
                            3:       r.row_pitch = PITCH_W'($urandom_range(0, need));
                            default: begin
                                if (h <= 2 && $urandom_range(0, 3) == 0) begin
                                    r.row_pitch = PITCH_W'($urandom_range(need, 255));
                                end else begin
                                    r.row_pitch = PITCH_W'(need + 1);
                                end
                            end
                        endcase
                    end
                    send_word(r, 1'b0, '0, used);
                    fed += used;

                    row_len = (r.row_pitch > need) ? int'(r.row_pitch) : need;
                    if (gd == GD_8BPP) begin
                        nbytes = w * h + $urandom_range(0, 1);
                    end else if (gd == GD_1BPP) begin
                        nbytes = row_len * (h - 1) + need + $urandom_range(0, 1);
                    end else begin
                        nbytes = $urandom_range(0, 2);
                    end
                    // Now and then the glyph is cut short and abandoned.
                    if (nbytes > 0 && $urandom_range(0, 7) == 0) begin
                        nbytes = $urandom_range(0, nbytes - 1);
                    end
                    for (j = 0; j < nbytes; j++) begin
                        r = junk_req();
                        r.req_type = REQ_DATA;
                        if (gd == GD_8BPP && $urandom_range(0, 1)) begin
                            r.data_byte = '0;
                        end
                        send_word(r, 1'b0, '0, used);
                        fed += used;
                    end
                end
            end
        end

        // Drain and let any late word show up before the verdict.
        quiet = 1'b0;
        settle();
        repeat (20) @(posedge i_clk);
        if (mismatch_count == 0 && fb_writes_due.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/gbce_pkg.sv
hw/rtl/gbce_req_if.sv
hw/rtl/gbce_res_if.sv
hw/rtl/gbce_lane.sv
hw/rtl/gbce_batch.sv
hw/rtl/glyph_bitmap_color_expander_unit.sv
tb/tb.sv
